// ===== rtl/core/ns_programmed_deadline_timer_macros.svh =====
// Assertion macros for the deadline timer.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef NS_PROGRAMMED_DEADLINE_TIMER_MACROS_SVH
`define NS_PROGRAMMED_DEADLINE_TIMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPDT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npdt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NPDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npdt: next-cycle check failed");

`endif

// ===== rtl/core/npdt_pkg.sv =====
// Shared types and constants of the deadline timer.
// Used by every module of the block; depends on nothing else.
package npdt_pkg;

    localparam int NUM_CPUS = 8;
    localparam int CPU_AW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

    // Width of the shared product/dividend and the number of divide steps.
    localparam int PROD_W    = 96;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_AW = 5;

    localparam logic [1:0] REG_FREQ   = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_DEFPER = 2'd2;

    localparam logic [31:0] FREQ_RESET   = 32'd10000000;
    localparam logic [61:0] SCALE_RESET  = 62'd429496729600;
    localparam logic [29:0] DEFPER_RESET = 30'd10000000;

    // Operation codes.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_REARM = 3'd3;
    localparam logic [2:0] OP_MASK  = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  cpu_index;
        logic [63:0] period_ns;
    } npdt_cmd_t;

    typedef struct packed {
        logic [63:0] time_ns;
        logic [63:0] deadline_ticks;
        logic        timer_pending;
        logic        was_armed;
    } npdt_rsp_t;

    typedef struct packed {
        logic [31:0] freq;
        logic [61:0] scale;
        logic [29:0] def_period;
    } npdt_cfg_t;

    // Request to the multiply/divide unit: product a*b, then either
    // bits [95:32] of it or its quotient by d.
    typedef struct packed {
        logic        start;
        logic        div;
        logic [63:0] a;
        logic [61:0] b;
        logic [31:0] d;
    } npdt_md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } npdt_md_rsp_t;

endpackage

// ===== rtl/core/npdt_cfg.sv =====
// Configuration register file of the deadline timer behind an APB-style port.
// Depends on npdt_pkg.
module npdt_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [npdt_pkg::CFG_AW-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output npdt_pkg::npdt_cfg_t           cfg
);
    import npdt_pkg::*;

    logic [31:0] freq_reg;
    logic [61:0] scale_reg;
    logic [29:0] defper_reg;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= FREQ_RESET;
            scale_reg  <= SCALE_RESET;
            defper_reg <= DEFPER_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FREQ:   freq_reg   <= pwdata[31:0];
                REG_SCALE:  scale_reg  <= pwdata[61:0];
                REG_DEFPER: defper_reg <= pwdata[29:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FREQ:   prdata = {32'd0, freq_reg};
            REG_SCALE:  prdata = {2'd0, scale_reg};
            REG_DEFPER: prdata = {34'd0, defper_reg};
            default:    prdata = 64'd0;
        endcase
    end

    assign cfg.freq       = freq_reg;
    assign cfg.scale      = scale_reg;
    assign cfg.def_period = defper_reg;

endmodule

// ===== rtl/core/npdt_period_mem.sv =====
// Per-CPU interval store: one write port, one registered read port.
// Entries never written read as zero. Depends on npdt_pkg.
module npdt_period_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [npdt_pkg::CPU_AW-1:0] wr_addr,
    input  logic [63:0]                 wr_data,
    input  logic                        rd_en,
    input  logic [npdt_pkg::CPU_AW-1:0] rd_addr,
    output logic [63:0]                 rd_data
);
    import npdt_pkg::*;

    logic [63:0] mem [NUM_CPUS];
    logic        valid_reg [NUM_CPUS];
    logic [63:0] rd_data_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 64'd0;

endmodule

// ===== rtl/core/npdt_muldiv.sv =====
// Iterative multiply and divide unit: a 64x62 product from four 32x32
// partial products, then an optional restoring division one bit per cycle.
// Depends on npdt_pkg.
module npdt_muldiv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  npdt_pkg::npdt_md_req_t req,
    output npdt_pkg::npdt_md_rsp_t rsp
);
    import npdt_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } u_state_t;

    u_state_t          u_state_reg, u_state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic [63:0]       a_reg, a_next;
    logic [61:0]       b_reg, b_next;
    logic [31:0]       d_reg, d_next;
    logic [63:0]       pp_reg, pp_next;
    logic [1:0]        sh_reg, sh_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [31:0]       rem_reg, rem_next;
    logic [63:0]       q_reg, q_next;

    logic [31:0]       a_half;
    logic [31:0]       b_half;
    logic [63:0]       pp_mul;
    logic [PROD_W-1:0] pp_shifted;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              ge;

    assign a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[1] ? {2'd0, b_reg[61:32]} : b_reg[31:0];
    assign pp_mul = 64'(a_half) * 64'(b_half);

    // Partial products land at bit 0, 32 or 64; bits above the product width drop.
    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = {32'd0, pp_reg};
            2'd1:    pp_shifted = {pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg[31:0], 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    assign trial = {rem_reg, acc_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        u_state_next = u_state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        div_next     = div_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        d_next       = d_reg;
        pp_next      = pp_reg;
        sh_next      = sh_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;

        case (u_state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    div_next     = req.div;
                    a_next       = req.a;
                    b_next       = req.b;
                    d_next       = req.d;
                    acc_next     = '0;
                    cnt_next     = '0;
                    u_state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                // The partial product is registered, then added into the accumulator from its register.
                if (!cnt_reg[2])
                begin
                    pp_next = pp_mul;
                    sh_next = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
                end
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                if (cnt_reg[2])
                begin
                    cnt_next = '0;
                    if (div_reg)
                    begin
                        rem_next     = '0;
                        q_next       = '0;
                        u_state_next = U_DIV;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        u_state_next = U_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            U_DIV:
            begin
                rem_next = ge ? diff[31:0] : trial[31:0];
                q_next   = {q_reg[62:0], ge};
                acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    done_next    = 1'b1;
                    u_state_next = U_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                u_state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_state_reg <= U_IDLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            u_state_reg <= u_state_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = div_reg ? q_reg : acc_reg[95:32];

endmodule

// ===== rtl/core/ns_programmed_deadline_timer.sv =====
// Deadline timer: one transfer in, one result out, one item in flight at a time.
// Arming and exact-division time reads use the 96-step divide in the shared
// multiply/divide unit; rearm first passes through a lookup state for the memory read.
// Scaled time reads use only the multiply; all other operations go straight to the final update.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_n, asynchronous) clears counters, deadline to all ones and every interval.
`include "ns_programmed_deadline_timer_macros.svh"

module ns_programmed_deadline_timer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  npdt_pkg::npdt_cmd_t          cmd,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output npdt_pkg::npdt_rsp_t          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [npdt_pkg::CFG_AW-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import npdt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_CALC = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [2:0]   op_reg, op_next;
    logic         cpu_ok_reg, cpu_ok_next;
    logic         armed_reg, armed_next;
    logic         tread_reg, tread_next;
    logic [63:0]  tick_count_reg, tick_count_next;
    logic [63:0]  base_count_reg, base_count_next;
    logic         started_reg, started_next;
    logic [63:0]  deadline_reg, deadline_next;
    npdt_rsp_t    rsp_reg, rsp_next;
    logic         rsp_valid_reg, rsp_valid_next;

    npdt_cfg_t    cfg;
    npdt_md_req_t md_req;
    npdt_md_rsp_t md_rsp;

    logic         cmd_accept;
    logic         cpu_ok;
    logic [63:0]  ns_fix;
    logic         freq_ok;
    logic         can_arm;
    logic [63:0]  delta;
    logic [63:0]  mem_rd;
    logic [63:0]  rearm_period;
    logic         mem_wr_en;
    logic         mem_rd_en;
    logic [63:0]  ticks;
    logic [63:0]  addend;
    logic [63:0]  sum;
    logic [63:0]  tick_new;
    logic [63:0]  deadline_new;
    logic         out_free;
    logic         commit;

    npdt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    npdt_period_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (CPU_AW'(cmd.cpu_index)),
        .wr_data (ns_fix),
        .rd_en   (mem_rd_en),
        .rd_addr (CPU_AW'(cmd.cpu_index)),
        .rd_data (mem_rd)
    );

    npdt_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && (state_reg == S_IDLE);

    assign cpu_ok  = ({29'd0, cmd.cpu_index} < 32'(NUM_CPUS));
    assign ns_fix  = (cmd.period_ns == 64'd0) ? 64'd1 : cmd.period_ns;
    assign freq_ok = (cfg.freq != 32'd0);
    assign can_arm = started_reg && freq_ok;
    assign delta   = tick_count_reg - base_count_reg;

    assign mem_wr_en = cmd_accept && (cmd.operation == OP_SET) && cpu_ok;
    assign mem_rd_en = cmd_accept && (cmd.operation == OP_REARM);

    // A slot holding zero, or a CPU outside the table, falls back to the default period.
    assign rearm_period = (cpu_ok_reg && (mem_rd != 64'd0)) ? mem_rd
                                                            : {34'd0, cfg.def_period};

    always_comb
    begin
        md_req.start = 1'b0;
        md_req.div   = 1'b1;
        md_req.a     = ns_fix;
        md_req.b     = {30'd0, cfg.freq};
        md_req.d     = NS_PER_SEC;
        if (cmd_accept)
        begin
            case (cmd.operation)
                OP_SET:
                begin
                    md_req.start = can_arm;
                end
                OP_READ:
                begin
                    md_req.start = freq_ok;
                    md_req.a     = delta;
                    if (cfg.scale != 62'd0)
                    begin
                        md_req.div = 1'b0;
                        md_req.b   = cfg.scale;
                    end
                    else
                    begin
                        md_req.b = {30'd0, NS_PER_SEC};
                        md_req.d = cfg.freq;
                    end
                end
                default:
                begin
                    md_req.start = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_LOOK)
        begin
            md_req.start = can_arm;
            md_req.a     = rearm_period;
        end
    end

    // Final update: one shared adder serves both the tick and the new deadline.
    assign ticks        = (md_rsp.result == 64'd0) ? 64'd1 : md_rsp.result;
    assign addend       = (op_reg == OP_TICK) ? 64'd1 : ticks;
    assign sum          = tick_count_reg + addend;
    assign tick_new     = (op_reg == OP_TICK) ? sum : tick_count_reg;
    assign deadline_new = (op_reg == OP_MASK) ? {64{1'b1}}
                        : (armed_reg ? sum : deadline_reg);

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign commit   = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cpu_ok_next     = cpu_ok_reg;
        armed_next      = armed_reg;
        tread_next      = tread_reg;
        tick_count_next = tick_count_reg;
        base_count_next = base_count_reg;
        started_next    = started_reg;
        deadline_next   = deadline_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next     = cmd.operation;
                    cpu_ok_next = cpu_ok;
                    armed_next  = (cmd.operation == OP_SET) && can_arm;
                    tread_next  = (cmd.operation == OP_READ) && freq_ok;
                    if (cmd.operation == OP_REARM)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (md_req.start)
                    begin
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LOOK:
            begin
                armed_next = can_arm;
                state_next = can_arm ? S_CALC : S_FIN;
            end
            S_CALC:
            begin
                if (md_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                begin
                    tick_count_next = tick_new;
                    deadline_next   = deadline_new;
                    if (op_reg == OP_START)
                    begin
                        base_count_next = tick_count_reg;
                        started_next    = 1'b1;
                    end
                    rsp_next.time_ns        = tread_reg ? md_rsp.result : 64'd0;
                    rsp_next.deadline_ticks = deadline_new;
                    rsp_next.timer_pending  = (tick_new >= deadline_new);
                    rsp_next.was_armed      = armed_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= 64'd0;
            base_count_reg <= 64'd0;
            started_reg    <= 1'b0;
            deadline_reg   <= {64{1'b1}};
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            base_count_reg <= base_count_next;
            started_reg    <= started_next;
            deadline_reg   <= deadline_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cpu_ok_reg <= cpu_ok_next;
        armed_reg  <= armed_next;
        tread_reg  <= tread_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The unit only finishes while the controller is waiting on it.
    `NPDT_ASSERT_SAME(a_done_in_calc, md_rsp.done, state_reg == S_CALC)
    // Starting the unit always hands control to the wait state.
    `NPDT_ASSERT_NEXT(a_start_to_calc, md_req.start, state_reg == S_CALC)
    // A result that reports arming can only come after start.
    `NPDT_ASSERT_SAME(a_armed_started, rsp_valid && rsp.was_armed, started_reg)

endmodule
